// ----- rtl/core/vyce_pkg.sv -----
`timescale 1ns / 1ps

package vyce_pkg;

	// fixed-point scaling of curvature
	localparam int FRAC_BITS_DEF = 24;

	// divider sizes
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int ACC_W     = 68;
	localparam int PROD_W    = 66;

	// configuration register map
	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_MIN_SPEED  = 2'd0;
	localparam logic [1:0] REG_CURV_ZERO  = 2'd1;
	localparam logic [1:0] REG_CURV_CLAMP = 2'd2;

	localparam logic [14:0] MIN_SPEED_RST  = 15'd100;
	localparam logic [24:0] CURV_ZERO_RST  = 25'd6711;
	localparam logic [30:0] CURV_CLAMP_RST = 31'd16777216;

	// arithmetic constants
	localparam logic signed [31:0] ACC_SCALE = 32'sd10000;
	localparam logic signed [31:0] YAW_K     = 32'sd411774832;
	localparam logic signed [31:0] CURV_MUL  = 32'sd100;
	localparam logic signed [31:0] CF_H1_NEG = -32'sd736608984;
	localparam logic signed [31:0] CF_H0     = 32'sd1778682517;
	localparam logic signed [31:0] CF_X      = 32'sd31668291;
	localparam logic signed [31:0] QF_H1_NEG = -32'sd173516;
	localparam logic signed [31:0] QF_H0     = 32'sd218393301;
	localparam logic signed [31:0] QF_D      = 32'sd685012566;
	localparam int CF_SHIFT = 30;
	localparam int QF_SHIFT = 36;

	localparam logic [3:0] CONF_FULL = 4'd10;
	localparam logic [14:0] CONF_BOUND [10] = '{
		15'd572, 15'd1144, 15'd1716, 15'd2288, 15'd2860,
		15'd5719, 15'd11438, 15'd17157, 15'd22876, 15'd28595
	};

	typedef struct packed {
		logic [15:0]        elapsed_ms;
		logic signed [15:0] speed_sample;
		logic [15:0]        heading_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] accel_out;
		logic signed [31:0] yaw_rate_out;
		logic signed [31:0] curvature_out;
		logic [3:0]         confidence_out;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ACC_MUL, S_ACC_DIV, S_ACC_WAIT,
		S_YAW_MUL, S_YAW_DIV, S_YAW_WAIT,
		S_CV_CHK, S_CV_MUL, S_CV_DIV, S_CV_WAIT, S_CV_MAC, S_CV_RND,
		S_CF_MAC, S_CF_RND, S_OUT
	} state_t;

	// saturate a sign and magnitude to 32-bit signed
	function automatic logic [31:0] sat_mag(input logic neg, input logic [ACC_W-1:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag > ACC_W'(33'h0_8000_0000)) r = 32'h8000_0000;
			else r = 32'd0 - mag[31:0];
		end else begin
			if (mag > ACC_W'(32'h7fff_ffff)) r = 32'h7fff_ffff;
			else r = mag[31:0];
		end
		return r;
	endfunction

	// round half away from zero by a constant shift, then saturate
	function automatic logic [31:0] rnd_sat(input logic signed [ACC_W-1:0] acc, input int sh);
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] r;
		m = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
		r = (m + (ACC_W'(1) << (sh - 1))) >> sh;
		return sat_mag(acc[ACC_W-1], r);
	endfunction

	// confidence level from filtered yaw-rate change
	function automatic logic [3:0] map_conf(input logic [31:0] f);
		logic [32:0] m;
		logic [3:0]  r;
		logic        hit;
		m   = f[31] ? (33'd0 - {f[31], f}) : {1'b0, f};
		r   = 4'd0;
		hit = 1'b0;
		if (m == 33'd0) begin
			r   = CONF_FULL;
			hit = 1'b1;
		end
		for (int i = 0; i < 10; i++) begin
			if (!hit && m <= {18'd0, CONF_BOUND[i]}) begin
				r   = 4'(9 - i);
				hit = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/vyce_div.sv -----
`timescale 1ns / 1ps

module vyce_div import vyce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// one restoring step per cycle
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- rtl/core/vehicle_yaw_curvature_estimator.sv -----
`timescale 1ns / 1ps
// a timed request runs the accel and yaw-rate divisions on the serial divider, then the curvature
// division and the curvature filter taps, then the confidence filter taps; below min_speed the
// curvature division is skipped; the first request after reset latches speed and heading and goes to the checks
// throughput: one request at a time, the next accepted the cycle after the result is
// registered; zero elapsed time requests after the first are dropped without a result
// reset: asynchronous active-low arst_n clears all history and restores register defaults
module vehicle_yaw_curvature_estimator import vyce_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam int CURV_SH = FRAC_BITS - 16;

	state_t state_q, state_nxt;

	logic [14:0] min_speed_q;
	logic [24:0] curv_zero_q;
	logic [30:0] curv_clamp_q;

	logic [15:0]        dt_q;
	logic signed [15:0] spd_q;
	logic [15:0]        hd_q;
	logic               init_q;
	logic signed [15:0] last_spd_q;
	logic [15:0]        last_hd_q;
	logic [31:0]        accel_q;
	logic [31:0]        yaw_q;
	logic [31:0]        ch0_q, ch1_q;
	logic [1:0]         fill_q;
	logic [31:0]        qh0_q, qh1_q;
	logic [31:0]        prev_yaw_q;
	logic [31:0]        raw_q;
	logic [31:0]        curv_q;
	logic [3:0]         conf_q;
	logic               neg_q;
	logic [1:0]         tap_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic [PROD_W-1:0]  prod_abs;
	logic [15:0]        spd_mag;
	logic               speed_ok;
	logic signed [16:0] dv;
	logic signed [16:0] dh;
	logic signed [16:0] dh_w;
	logic signed [32:0] dyaw;
	logic [31:0]        div_sat;
	logic [31:0]        y_rnd;
	logic [32:0]        y_mag;
	logic [31:0]        f_rnd;
	logic               cfg_wr;
	logic               out_free;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q  <= MIN_SPEED_RST;
			curv_zero_q  <= CURV_ZERO_RST;
			curv_clamp_q <= CURV_CLAMP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MIN_SPEED:  min_speed_q  <= pwdata[14:0];
				REG_CURV_ZERO:  curv_zero_q  <= pwdata[24:0];
				REG_CURV_CLAMP: curv_clamp_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MIN_SPEED:  prdata = {17'd0, min_speed_q};
			REG_CURV_ZERO:  prdata = {7'd0, curv_zero_q};
			REG_CURV_CLAMP: prdata = {1'b0, curv_clamp_q};
			default:        prdata = 32'd0;
		endcase
	end

	// derived quantities
	assign spd_mag  = last_spd_q[15] ? (16'd0 - last_spd_q) : last_spd_q;
	assign speed_ok = (spd_mag != 16'd0) && (spd_mag >= {1'b0, min_speed_q});
	assign dv       = {spd_q[15], spd_q} - {last_spd_q[15], last_spd_q};
	assign dh       = $signed({1'b0, last_hd_q}) - $signed({1'b0, hd_q});
	assign dyaw     = {yaw_q[31], yaw_q} - {prev_yaw_q[31], prev_yaw_q};
	assign prod_abs = prod_q[PROD_W-1] ? (PROD_W'(0) - prod_q) : prod_q;
	assign div_sat  = sat_mag(neg_q, {{(ACC_W-DIV_NUM_W){1'b0}}, div_rsp.quo});
	assign y_rnd    = rnd_sat(acc_q, CF_SHIFT);
	assign y_mag    = y_rnd[31] ? (33'd0 - {y_rnd[31], y_rnd}) : {1'b0, y_rnd};
	assign f_rnd    = rnd_sat(acc_q, QF_SHIFT);
	assign out_free = !out_valid_q || !out_stall;

	// heading difference wrapped to a half turn
	always_comb begin
		dh_w = dh;
		if (dh > 17'sd32768) dh_w = dh - 17'sd65536;
		else if (dh < -17'sd32768) dh_w = dh + 17'sd65536;
	end

	// next state, multiplier operands and divider request
	always_comb begin
		state_nxt   = state_q;
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		in_stall    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!init_q) state_nxt = S_CV_CHK;
					else if (in_data.elapsed_ms != 16'd0) state_nxt = S_ACC_MUL;
				end
			end
			S_ACC_MUL: begin
				mul_a     = {{17{dv[16]}}, dv};
				mul_b     = ACC_SCALE;
				state_nxt = S_ACC_DIV;
			end
			S_ACC_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = prod_abs[DIV_NUM_W-1:0] + {48'd0, 1'b0, dt_q[15:1]};
				div_req.den   = {16'd0, dt_q};
				state_nxt     = S_ACC_WAIT;
			end
			S_ACC_WAIT: if (div_rsp.done) state_nxt = S_YAW_MUL;
			S_YAW_MUL: begin
				mul_a     = {{17{dh_w[16]}}, dh_w};
				mul_b     = YAW_K;
				state_nxt = S_YAW_DIV;
			end
			S_YAW_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = prod_abs[DIV_NUM_W-1:0] + {33'd0, dt_q, 15'd0};
				div_req.den   = {dt_q, 16'd0};
				state_nxt     = S_YAW_WAIT;
			end
			S_YAW_WAIT: if (div_rsp.done) state_nxt = S_CV_CHK;
			S_CV_CHK: state_nxt = speed_ok ? S_CV_MUL : S_CF_MAC;
			S_CV_MUL: begin
				mul_a     = {{2{yaw_q[31]}}, yaw_q};
				mul_b     = CURV_MUL;
				state_nxt = S_CV_DIV;
			end
			S_CV_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = (prod_abs[DIV_NUM_W-1:0] << CURV_SH)
					+ {49'd0, spd_mag[15:1]};
				div_req.den   = {16'd0, spd_mag};
				state_nxt     = S_CV_WAIT;
			end
			S_CV_WAIT: begin
				if (div_rsp.done) state_nxt = (fill_q < 2'd2) ? S_CF_MAC : S_CV_MAC;
			end
			S_CV_MAC: begin
				case (tap_q)
					2'd0: begin
						mul_a = {{2{ch1_q[31]}}, ch1_q};
						mul_b = CF_H1_NEG;
					end
					2'd1: begin
						mul_a = {{2{ch0_q[31]}}, ch0_q};
						mul_b = CF_H0;
					end
					default: begin
						mul_a = {{2{raw_q[31]}}, raw_q};
						mul_b = CF_X;
					end
				endcase
				if (tap_q == 2'd3) state_nxt = S_CV_RND;
			end
			S_CV_RND: state_nxt = S_CF_MAC;
			S_CF_MAC: begin
				case (tap_q)
					2'd0: begin
						mul_a = {{2{qh1_q[31]}}, qh1_q};
						mul_b = QF_H1_NEG;
					end
					2'd1: begin
						mul_a = {{2{qh0_q[31]}}, qh0_q};
						mul_b = QF_H0;
					end
					default: begin
						mul_a = {dyaw[32], dyaw};
						mul_b = QF_D;
					end
				endcase
				if (tap_q == 2'd3) state_nxt = S_CF_RND;
			end
			S_CF_RND: state_nxt = S_OUT;
			S_OUT: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a * mul_b);
	end

	// multiply-accumulate over three filter taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= 2'd0;
			acc_q <= '0;
		end else if (state_q == S_CV_MAC || state_q == S_CF_MAC) begin
			tap_q <= tap_q + 2'd1;
			if (tap_q != 2'd0) acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		end else begin
			tap_q <= 2'd0;
			acc_q <= '0;
		end
	end

	// request latch and sign of the pending quotient
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			dt_q  <= in_data.elapsed_ms;
			spd_q <= in_data.speed_sample;
			hd_q  <= in_data.heading_sample;
		end
		if (state_q == S_ACC_DIV || state_q == S_YAW_DIV) neg_q <= prod_q[PROD_W-1];
		if (state_q == S_CV_DIV) neg_q <= prod_q[PROD_W-1] ^ last_spd_q[15];
	end

	// estimator and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b0;
			last_spd_q <= '0;
			last_hd_q  <= '0;
			accel_q    <= '0;
			yaw_q      <= '0;
			ch0_q      <= '0;
			ch1_q      <= '0;
			fill_q     <= '0;
			qh0_q      <= '0;
			qh1_q      <= '0;
			prev_yaw_q <= '0;
			raw_q      <= '0;
			curv_q     <= '0;
			conf_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					curv_q <= '0;
					if (in_valid && !init_q) begin
						last_spd_q <= in_data.speed_sample;
						last_hd_q  <= in_data.heading_sample;
						init_q     <= 1'b1;
					end
				end
				S_ACC_WAIT: if (div_rsp.done) accel_q <= div_sat;
				S_YAW_WAIT: begin
					if (div_rsp.done) begin
						yaw_q      <= div_sat;
						last_spd_q <= spd_q;
						last_hd_q  <= hd_q;
					end
				end
				S_CV_WAIT: begin
					if (div_rsp.done) begin
						if (fill_q < 2'd2) begin
							ch1_q  <= ch0_q;
							ch0_q  <= div_sat;
							fill_q <= fill_q + 2'd1;
						end else begin
							raw_q <= div_sat;
						end
					end
				end
				S_CV_RND: begin
					ch1_q <= ch0_q;
					ch0_q <= y_rnd;
					if (y_mag < {8'd0, curv_zero_q}) curv_q <= '0;
					else if (y_mag > {2'd0, curv_clamp_q}) begin
						curv_q <= y_rnd[31] ? (32'd0 - {1'b0, curv_clamp_q})
							: {1'b0, curv_clamp_q};
					end else curv_q <= y_rnd;
				end
				S_CF_RND: begin
					qh1_q      <= qh0_q;
					qh0_q      <= f_rnd;
					prev_yaw_q <= yaw_q;
					conf_q     <= map_conf(f_rnd);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.accel_out      <= accel_q;
			out_q.yaw_rate_out   <= yaw_q;
			out_q.curvature_out  <= curv_q;
			out_q.confidence_out <= conf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	vyce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ----- rtl/core/vyce_chk.sv -----
`timescale 1ns / 1ps

module vyce_chk import vyce_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// a timed request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.elapsed_ms != 16'd0 |=> in_stall)
		else $error("block not busy after a request");

	// a result appears only after the block was busy
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// confidence stays in tenths
	a_conf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.confidence_out <= CONF_FULL)
		else $error("confidence out of range");

endmodule

bind vehicle_yaw_curvature_estimator vyce_chk u_vyce_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- tb/tb_vehicle_yaw_curvature_estimator.sv -----
`timescale 1ns / 1ps
module tb_vehicle_yaw_curvature_estimator;
	import vyce_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT   = 20000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;

	vehicle_yaw_curvature_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	in_item_t  pending_samples[$];
	out_item_t expected_estimates[$];
	int        idle_pct;
	bit        failed;
	int        quiet_cycles;
	logic [15:0] gen_heading;

	// predictor copy of registers and estimator state
	int unsigned est_min_speed, est_zero_thr, est_clamp;
	bit          est_init;
	int          est_speed, est_accel, est_yaw, est_conf_prev_yaw;
	int unsigned est_heading;
	int          est_curv_hist[2], est_conf_hist[2];
	int unsigned est_curv_fill;

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// divide rounding half away from zero
	function automatic longint div_round(input longint num, input longint den);
		longint q;
		q = (mag(num) + mag(den) / 2) / mag(den);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic int sat32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return int'(v);
	endfunction

	function automatic logic [3:0] confidence_level(input int f);
		longint m;
		m = mag(longint'(f));
		if (m == 0) return CONF_FULL;
		for (int i = 0; i < 10; i++)
			if (m <= longint'(CONF_BOUND[i])) return 4'(9 - i);
		return 4'd0;
	endfunction

	task automatic reset_estimator();
		est_min_speed = MIN_SPEED_RST;
		est_zero_thr = CURV_ZERO_RST;
		est_clamp = CURV_CLAMP_RST;
		est_init = 0;
		est_speed = 0;
		est_heading = 0;
		est_accel = 0;
		est_yaw = 0;
		est_curv_hist = '{0, 0};
		est_curv_fill = 0;
		est_conf_hist = '{0, 0};
		est_conf_prev_yaw = 0;
	endtask

	// compute the estimate for one accepted sample
	task automatic estimate_sample(input in_item_t s);
		longint spd, d, acc, y, ym;
		int raw, curv, f;
		out_item_t e;
		spd = longint'(s.speed_sample);
		curv = 0;
		if (!est_init) begin
			est_speed = int'(spd);
			est_heading = s.heading_sample;
			est_init = 1;
		end else if (s.elapsed_ms == 0) begin
			return;
		end else begin
			d = longint'(est_heading) - longint'(s.heading_sample);
			if (d > 32768) d -= 65536;
			else if (d < -32768) d += 65536;
			est_accel = sat32(div_round((spd - est_speed) * ACC_SCALE, s.elapsed_ms));
			est_yaw = sat32(div_round(d * YAW_K, longint'(s.elapsed_ms) * 65536));
			est_speed = int'(spd);
			est_heading = s.heading_sample;
		end
		// curvature path, skipped at low speed
		if (est_speed != 0 && mag(est_speed) >= est_min_speed) begin
			raw = sat32(div_round(longint'(est_yaw) * CURV_MUL * (64'sd1 << (FRAC_BITS_DEF - 16)),
				est_speed));
			if (est_curv_fill < 2) begin
				est_curv_hist[1] = est_curv_hist[0];
				est_curv_hist[0] = raw;
				est_curv_fill++;
			end else begin
				acc = longint'(est_curv_hist[1]) * CF_H1_NEG + longint'(est_curv_hist[0]) * CF_H0
					+ longint'(raw) * CF_X;
				y = sat32(div_round(acc, 64'sd1 << CF_SHIFT));
				ym = mag(y);
				est_curv_hist[1] = est_curv_hist[0];
				est_curv_hist[0] = int'(y);
				if (ym < est_zero_thr) curv = 0;
				else if (ym > est_clamp) curv = y < 0 ? -int'(est_clamp) : int'(est_clamp);
				else curv = int'(y);
			end
		end
		// confidence filter on yaw-rate change
		acc = longint'(est_conf_hist[1]) * QF_H1_NEG + longint'(est_conf_hist[0]) * QF_H0
			+ (longint'(est_yaw) - longint'(est_conf_prev_yaw)) * QF_D;
		f = sat32(div_round(acc, 64'sd1 << QF_SHIFT));
		est_conf_hist[1] = est_conf_hist[0];
		est_conf_hist[0] = f;
		est_conf_prev_yaw = est_yaw;
		e.accel_out = est_accel;
		e.yaw_rate_out = est_yaw;
		e.curvature_out = curv;
		e.confidence_out = confidence_level(f);
		expected_estimates.push_back(e);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) estimate_sample(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_data  <= pending_samples.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_estimates.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					failed = 1;
				end else begin
					e = expected_estimates.pop_front();
					if (out_data.accel_out !== e.accel_out) begin
						$display("%0t: accel_out expected %0d actual %0d", $time,
							e.accel_out, out_data.accel_out);
						failed = 1;
					end
					if (out_data.yaw_rate_out !== e.yaw_rate_out) begin
						$display("%0t: yaw_rate_out expected %0d actual %0d", $time,
							e.yaw_rate_out, out_data.yaw_rate_out);
						failed = 1;
					end
					if (out_data.curvature_out !== e.curvature_out) begin
						$display("%0t: curvature_out expected %0d actual %0d", $time,
							e.curvature_out, out_data.curvature_out);
						failed = 1;
					end
					if (out_data.confidence_out !== e.confidence_out) begin
						$display("%0t: confidence_out expected %0d actual %0d", $time,
							e.confidence_out, out_data.confidence_out);
						failed = 1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_vehicle_yaw_curvature_estimator failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MIN_SPEED:  est_min_speed = value & 32'h7fff;
			REG_CURV_ZERO:  est_zero_thr = value & 32'h1ff_ffff;
			REG_CURV_CLAMP: est_clamp = value & 32'h7fff_ffff;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] ms, input logic [31:0] zt, input logic [31:0] cl);
		reg_write(REG_MIN_SPEED, ms);
		reg_write(REG_CURV_ZERO, zt);
		reg_write(REG_CURV_CLAMP, cl);
	endtask

	task automatic push_sample(input int dt, input int spd, input int hd);
		in_item_t s;
		s.elapsed_ms = 16'(dt);
		s.speed_sample = 16'(spd);
		s.heading_sample = 16'(hd);
		pending_samples.push_back(s);
		gen_heading = 16'(hd);
	endtask

	// mostly plausible driving with random content, some noise
	task automatic push_random(input int n);
		int dt, spd, hd, pick;
		spd = $urandom_range(3000);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 5) dt = 0;
			else if (pick < 15) dt = $urandom_range(65535);
			else if (pick < 20) dt = $urandom_range(1, 5);
			else dt = $urandom_range(50, 200);
			pick = $urandom_range(99);
			if (pick < 10) spd = $signed(16'($urandom));
			else if (pick < 15) spd = $urandom_range(150);
			else if (pick < 18) spd = 0;
			else spd = spd + int'($urandom_range(200)) - 100;
			if (spd > 32767) spd = 32767;
			if (spd < -32768) spd = -32768;
			pick = $urandom_range(99);
			if (pick < 10) hd = $urandom_range(65535);
			else hd = gen_heading + int'($urandom_range(600)) - 300;
			push_sample(dt, spd, hd);
		end
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !in_valid && expected_estimates.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		failed = 0;
		quiet_cycles = 0;
		idle_pct = 11;
		gen_heading = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		reset_estimator();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first sample with no elapsed time, repeats, half-turn cases, extremes
		push_sample(0, 2000, 16'h8000);
		push_sample(0, 500, 16'h1234);
		push_sample(100, 2000, 16'h0000);
		push_sample(100, 2000, 16'h8000);
		push_sample(100, 2000, 16'h7fff);
		push_sample(1, 32767, 16'hffff);
		push_sample(1, -32768, 16'h0001);
		push_sample(65535, -32768, 16'hc000);
		push_sample(1, 100, 16'h4000);
		push_sample(1, 100, 16'h0000);
		push_sample(100, 99, 16'h0100);
		push_sample(100, 0, 16'h0200);
		push_sample(100, -100, 16'h0300);
		push_sample(1, 1, 16'h8300);
		push_sample(50, 1500, 16'h8310);
		push_sample(50, 1500, 16'h8300);
		push_sample(65535, 32767, 16'h0000);
		drain();

		// lowest register settings
		set_regs(32'd0, 32'd0, 32'd0);
		push_sample(100, 0, 16'h0010);
		push_sample(100, 1, 16'h0400);
		push_sample(100, -1, 16'h0000);
		push_random(250);
		drain();

		// highest min_speed and clamp settings, zero threshold at 16777216, no idling on either side
		idle_pct = 0;
		set_regs(32'h7fff, 32'd16777216, 32'h7fff_ffff);
		push_sample(100, 32767, 16'h1000);
		push_sample(100, -32768, 16'h2000);
		push_random(250);
		drain();
		idle_pct = 11;

		// register bits beyond the fields are dropped
		set_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		push_random(200);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_regs($urandom_range(400), $urandom_range(200000), $urandom_range(1, 1 << 26));
			push_random(150);
			drain();
		end

		set_regs(MIN_SPEED_RST, CURV_ZERO_RST, CURV_CLAMP_RST);
		push_random(150);
		drain();

		if (!failed)
			$display("tb_vehicle_yaw_curvature_estimator passed");
		else
			$display("tb_vehicle_yaw_curvature_estimator failed");
		$finish;
	end

endmodule
